### hdl/blfrs_pkg.sv
// Shared types, constants and helpers for the backlight flash ramp sequencer.
package blfrs_pkg;

  // Field and register widths.
  localparam int LEVEL_W    = 12;
  localparam int RAMP_W     = 14;
  localparam int WAIT_W     = 8;
  localparam int HOLD_W     = 10;
  localparam int STEP_W     = 8;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;

  // Ticks per hold wait and the saturation range of a written level.
  localparam int HOLD_WAIT_TICKS = 8;
  localparam int LEVEL_BITS      = 12;
  localparam int LEVEL_MAX       = (1 << LEVEL_BITS) - 1;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_MODE = 2'd1,
    OP_START    = 2'd2,
    OP_STOP     = 2'd3
  } op_t;

  // Mode codes; the fourth code is not a mode and is ignored on a set.
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_TRIGGER = 2'd1;
  localparam logic [1:0] MODE_EXIT    = 2'd2;
  localparam logic [1:0] MODE_BAD     = 2'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_LEVEL  = 3'd0,
    CFG_END_LEVEL    = 3'd1,
    CFG_UP_STEP      = 3'd2,
    CFG_BACK_STEP    = 3'd3,
    CFG_FP_CAP_LEVEL = 3'd4,
    CFG_HOLD_STEPS   = 3'd5,
    CFG_UP_WAIT      = 3'd6,
    CFG_BACK_WAIT    = 3'd7
  } cfg_idx_t;

  // Sequence phases, one-hot.
  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_UP        = 8'b0000_0010,
    PH_HOLD      = 8'b0000_0100,
    PH_HOLD_END  = 8'b0000_1000,
    PH_BACK      = 8'b0001_0000,
    PH_BACK_UP   = 8'b0010_0000,
    PH_BACK_DOWN = 8'b0100_0000,
    PH_FINAL     = 8'b1000_0000
  } phase_t;

  // Configuration register set.
  typedef struct packed {
    logic [LEVEL_W-1:0] start_level;
    logic [LEVEL_W-1:0] end_level;
    logic [STEP_W-1:0]  up_step;
    logic [STEP_W-1:0]  back_step;
    logic [LEVEL_W-1:0] fp_cap_level;
    logic [HOLD_W-1:0]  hold_steps;
    logic [WAIT_W-1:0]  up_wait;
    logic [WAIT_W-1:0]  back_wait;
  } cfg_t;

  // Sequencer state carried between words.
  typedef struct packed {
    phase_t             phase;
    logic [RAMP_W-1:0]  ramp_level;
    logic [WAIT_W-1:0]  wait_count;
    logic [HOLD_W-1:0]  hold_count;
    logic [LEVEL_W-1:0] back_target;
  } seq_state_t;

  // Per-word steering of the sequencer.
  typedef struct packed {
    logic               exit_a;
    logic               exit_b;
    logic               hbm_on;
    logic [LEVEL_W-1:0] target_level;
  } seq_ctl_t;

  // What the sequencer reports for one word.
  typedef struct packed {
    logic               write_valid;
    logic [LEVEL_W-1:0] write_level;
    logic               finish_set;
  } seq_res_t;

  // Clamp a ramp level to the backlight range and cut it to the port width.
  function automatic logic [LEVEL_W-1:0] sat_level(input logic [RAMP_W-1:0] v);
    logic [LEVEL_W-1:0] res;
    if (int'(v) > LEVEL_MAX) begin
      res = LEVEL_W'(LEVEL_MAX);
    end else begin
      res = v[LEVEL_W-1:0];
    end
    return res;
  endfunction

endpackage

### hdl/blfrs_ifs.sv
// Valid/ready channel interfaces for the input and result words.
interface blfrs_in_if import blfrs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [1:0]         mode_value;
  logic [LEVEL_W-1:0] target_level;
  logic               hbm_on;
  logic               power_on;

  modport source (output valid, op, mode_value, target_level, hbm_on, power_on,
                  input ready);
  modport sink (input valid, op, mode_value, target_level, hbm_on, power_on,
                output ready);
endinterface

interface blfrs_out_if import blfrs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               write_valid;
  logic [LEVEL_W-1:0] write_level;
  logic               finished;
  logic [1:0]         mode_now;
  logic               seq_active;

  modport source (output valid, write_valid, write_level, finished, mode_now, seq_active,
                  input ready);
  modport sink (input valid, write_valid, write_level, finished, mode_now, seq_active,
                output ready);
endinterface

### hdl/blfrs_seq.sv
// Phase walker: runs sequence actions from a given phase until a write, a wait or idle.
module blfrs_seq import blfrs_pkg::*; (
  input  cfg_t       cfg,
  input  seq_ctl_t   ctl,
  input  seq_state_t st_in,
  output seq_state_t st_out,
  output seq_res_t   res
);

  // Longest chain of phase changes before an action must stop is five.
  localparam int SEQ_PASSES = 6;

  // Each pass handles one phase; passes after the stopping one leave everything alone.
  always_comb begin
    seq_state_t st;
    seq_res_t   r;
    logic       done;
    st   = st_in;
    r    = '0;
    done = 1'b0;
    for (int i = 0; i < SEQ_PASSES; i++) begin
      if (!done) begin
        unique case (st.phase)
          PH_UP: begin
            if (st.ramp_level >= RAMP_W'(cfg.end_level) || ctl.exit_a ||
                (ctl.hbm_on && st.ramp_level > RAMP_W'(cfg.fp_cap_level))) begin
              st.hold_count = cfg.hold_steps;
              st.phase      = PH_HOLD;
            end else begin
              r.write_valid = 1'b1;
              r.write_level = sat_level(st.ramp_level);
              st.ramp_level = st.ramp_level + RAMP_W'(cfg.up_step);
              st.wait_count = cfg.up_wait;
              done          = 1'b1;
            end
          end
          PH_HOLD: begin
            if (ctl.exit_a) begin
              st.phase = PH_BACK;
            end else begin
              st.wait_count = WAIT_W'(HOLD_WAIT_TICKS);
              if (st.hold_count == '0) begin
                st.phase = PH_HOLD_END;
              end else begin
                st.hold_count = st.hold_count - 1'b1;
              end
              done = 1'b1;
            end
          end
          PH_HOLD_END: begin
            st.phase = PH_BACK;
          end
          PH_BACK: begin
            st.back_target = ctl.target_level;
            if (st.ramp_level < RAMP_W'(ctl.target_level)) begin
              st.phase = PH_BACK_UP;
            end else if (st.ramp_level > RAMP_W'(ctl.target_level)) begin
              st.phase = PH_BACK_DOWN;
            end else begin
              st.phase = PH_FINAL;
            end
          end
          PH_BACK_UP: begin
            if (st.ramp_level >= RAMP_W'(st.back_target) || ctl.exit_b) begin
              st.phase = PH_FINAL;
            end else begin
              r.write_valid = 1'b1;
              r.write_level = sat_level(st.ramp_level);
              st.ramp_level = st.ramp_level + RAMP_W'(cfg.back_step);
              st.wait_count = cfg.back_wait;
              done          = 1'b1;
            end
          end
          PH_BACK_DOWN: begin
            if (st.ramp_level <= RAMP_W'(st.back_target) || ctl.exit_b) begin
              st.phase = PH_FINAL;
            end else begin
              r.write_valid = 1'b1;
              r.write_level = sat_level(st.ramp_level);
              // A step past zero lands on zero.
              if (st.ramp_level >= RAMP_W'(cfg.back_step)) begin
                st.ramp_level = st.ramp_level - RAMP_W'(cfg.back_step);
              end else begin
                st.ramp_level = '0;
              end
              st.wait_count = cfg.back_wait;
              done          = 1'b1;
            end
          end
          PH_FINAL: begin
            r.write_valid = 1'b1;
            r.write_level = ctl.target_level;
            r.finish_set  = 1'b1;
            st.phase      = PH_IDLE;
            st.wait_count = '0;
            done          = 1'b1;
          end
          default: begin
            st.phase = PH_IDLE;
            done     = 1'b1;
          end
        endcase
      end
    end
    st_out = st;
    res    = r;
  end

endmodule

### hdl/backlight_flash_ramp_sequencer.sv
// A result word is registered and shown in the cycle after its input word is accepted.
// Throughput: one input word per cycle unless a stalled receiver holds the result register;
// the result register frees as it is taken, and the multi-pass phase walker is combinational.
// Reset (synchronous, rst_n low): registers return to their defaults, mode off,
// not running, finished set, sequence idle, no pending trigger, no result held.
module backlight_flash_ramp_sequencer import blfrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  blfrs_in_if.sink              in_ch,
  blfrs_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg_r;
  logic [1:0] mode_r, mode_nxt;
  logic       running_r, running_nxt;
  logic       finish_r, finish_nxt;
  logic       retrig_r, retrig_nxt;
  seq_state_t seq_r, seq_nxt;

  seq_state_t seq_in, seq_out;
  seq_ctl_t   seq_ctl;
  seq_res_t   seq_res;
  logic       run_seq;
  logic       in_acc;
  logic [WAIT_W-1:0] wait_dec;

  logic               out_valid_r;
  logic               wr_valid_r, wr_valid_nxt;
  logic [LEVEL_W-1:0] wr_level_r, wr_level_nxt;
  logic               fin_out_r;
  logic [1:0]         mode_out_r;
  logic               active_r;

  // Input is taken whenever the result register is empty or being emptied.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_level  <= LEVEL_W'(2);
      cfg_r.end_level    <= LEVEL_W'(236);
      cfg_r.up_step      <= STEP_W'(1);
      cfg_r.back_step    <= STEP_W'(6);
      cfg_r.fp_cap_level <= LEVEL_W'(255);
      cfg_r.hold_steps   <= HOLD_W'(600);
      cfg_r.up_wait      <= WAIT_W'(1);
      cfg_r.back_wait    <= WAIT_W'(6);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_LEVEL:  cfg_r.start_level  <= cfg_wdata[LEVEL_W-1:0];
        CFG_END_LEVEL:    cfg_r.end_level    <= cfg_wdata[LEVEL_W-1:0];
        CFG_UP_STEP:      cfg_r.up_step      <= cfg_wdata[STEP_W-1:0];
        CFG_BACK_STEP:    cfg_r.back_step    <= cfg_wdata[STEP_W-1:0];
        CFG_FP_CAP_LEVEL: cfg_r.fp_cap_level <= cfg_wdata[LEVEL_W-1:0];
        CFG_HOLD_STEPS:   cfg_r.hold_steps   <= cfg_wdata[HOLD_W-1:0];
        CFG_UP_WAIT:      cfg_r.up_wait      <= cfg_wdata[WAIT_W-1:0];
        CFG_BACK_WAIT:    cfg_r.back_wait    <= cfg_wdata[WAIT_W-1:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  // Exit conditions seen by the phase walker.
  assign seq_ctl.exit_a       = (mode_r == MODE_OFF) || (mode_r == MODE_EXIT) || !running_r;
  assign seq_ctl.exit_b       = (mode_r == MODE_EXIT) || !running_r;
  assign seq_ctl.hbm_on       = in_ch.hbm_on;
  assign seq_ctl.target_level = in_ch.target_level;

  assign wait_dec = (seq_r.wait_count != '0) ? seq_r.wait_count - 1'b1 : seq_r.wait_count;

  blfrs_seq u_seq (
    .cfg    (cfg_r),
    .ctl    (seq_ctl),
    .st_in  (seq_in),
    .st_out (seq_out),
    .res    (seq_res)
  );

  // Decode one word: control updates and the entry point for the phase walker.
  always_comb begin
    mode_nxt    = mode_r;
    running_nxt = running_r;
    finish_nxt  = finish_r;
    retrig_nxt  = retrig_r;
    seq_in      = seq_r;
    run_seq     = 1'b0;
    unique case (op_t'(in_ch.op))
      OP_TICK: begin
        if (seq_r.phase == PH_IDLE) begin
          if (retrig_r) begin
            retrig_nxt = 1'b0;
            if (in_ch.power_on && mode_r == MODE_TRIGGER && running_r) begin
              seq_in.ramp_level = RAMP_W'(cfg_r.start_level);
              seq_in.phase      = PH_UP;
              run_seq           = 1'b1;
            end
          end
        end else begin
          seq_in.wait_count = wait_dec;
          run_seq           = (wait_dec == '0);
        end
      end
      OP_SET_MODE: begin
        if (in_ch.mode_value != MODE_BAD && in_ch.mode_value != mode_r) begin
          mode_nxt = in_ch.mode_value;
          if (in_ch.mode_value == MODE_TRIGGER && running_r) begin
            finish_nxt = 1'b0;
            retrig_nxt = 1'b1;
          end
        end
      end
      OP_START: begin
        running_nxt = 1'b1;
        if (mode_r == MODE_TRIGGER) begin
          finish_nxt = 1'b0;
          retrig_nxt = 1'b1;
        end
      end
      OP_STOP: begin
        finish_nxt  = 1'b1;
        running_nxt = 1'b0;
        retrig_nxt  = 1'b0;
        if (seq_r.phase != PH_IDLE) begin
          seq_in.phase = PH_FINAL;
          run_seq      = 1'b1;
        end
      end
      default: begin
        run_seq = 1'b0;
      end
    endcase

    // Merge the walker's outcome.
    seq_nxt      = run_seq ? seq_out : seq_in;
    wr_valid_nxt = run_seq && seq_res.write_valid;
    wr_level_nxt = wr_valid_nxt ? seq_res.write_level : '0;
    if (run_seq && seq_res.finish_set) begin
      finish_nxt = 1'b1;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_OFF;
      running_r       <= 1'b0;
      finish_r        <= 1'b1;
      retrig_r        <= 1'b0;
      seq_r.phase       <= PH_IDLE;
      seq_r.ramp_level  <= '0;
      seq_r.wait_count  <= '0;
      seq_r.hold_count  <= '0;
      seq_r.back_target <= '0;
    end else if (in_acc) begin
      mode_r    <= mode_nxt;
      running_r <= running_nxt;
      finish_r  <= finish_nxt;
      retrig_r  <= retrig_nxt;
      seq_r     <= seq_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      wr_valid_r <= wr_valid_nxt;
      wr_level_r <= wr_level_nxt;
      fin_out_r  <= finish_nxt;
      mode_out_r <= mode_nxt;
      active_r   <= (seq_nxt.phase != PH_IDLE);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.write_valid = wr_valid_r;
  assign out_ch.write_level = wr_level_r;
  assign out_ch.finished    = fin_out_r;
  assign out_ch.mode_now    = mode_out_r;
  assign out_ch.seq_active  = active_r;

endmodule

### sim/blfrs_ramp_checker.sv
`timescale 1ns / 1ps
// Result checker for the backlight ramp sequencer: predicts every result word and compares it.
module blfrs_ramp_checker import blfrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  blfrs_in_if                   in_ch,
  blfrs_out_if                  out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    words_owed
);

  // One result word as the block should report it.
  typedef struct packed {
    logic               write_valid;
    logic [LEVEL_W-1:0] write_level;
    logic               finished;
    logic [1:0]         mode_now;
    logic               seq_active;
  } bl_word_t;

  bl_word_t owed_q[$];
  int       errs;

  // Predicted register set and sequencer state.
  cfg_t               regs;
  logic [1:0]         mode_r;
  logic               running_r;
  logic               finished_r;
  logic               retrig_r;
  phase_t             ph;
  logic [RAMP_W-1:0]  ramp;
  logic [WAIT_W-1:0]  wait_left;
  logic [HOLD_W-1:0]  holds_left;
  logic [LEVEL_W-1:0] back_goal;

  // A ramp level as it appears on the write port: anything beyond the range is pinned.
  function automatic logic [LEVEL_W-1:0] level_on_wire(input logic [RAMP_W-1:0] v);
    logic [LEVEL_W-1:0] res;
    res = (v > RAMP_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : v[LEVEL_W-1:0];
    return res;
  endfunction

  // Walk the phases until a write, a wait or idle. Returns 1 when a write happens.
  function automatic logic walk_phases(input logic [LEVEL_W-1:0] tgt, input logic hbm,
                                       output logic [LEVEL_W-1:0] lvl_out);
    logic leave_a, leave_b, wrote, done;
    wrote   = 1'b0;
    done    = 1'b0;
    lvl_out = '0;
    while (!done) begin
      leave_a = (mode_r == MODE_OFF) || (mode_r == MODE_EXIT) || !running_r;
      leave_b = (mode_r == MODE_EXIT) || !running_r;
      case (ph)
        PH_UP: begin
          if (ramp >= RAMP_W'(regs.end_level) || leave_a ||
              (hbm && ramp > RAMP_W'(regs.fp_cap_level))) begin
            holds_left = regs.hold_steps;
            ph = PH_HOLD;
          end else begin
            lvl_out   = level_on_wire(ramp);
            ramp      = ramp + RAMP_W'(regs.up_step);
            wait_left = regs.up_wait;
            wrote     = 1'b1;
            done      = 1'b1;
          end
        end
        PH_HOLD: begin
          if (leave_a) begin
            ph = PH_BACK;
          end else begin
            wait_left = WAIT_W'(HOLD_WAIT_TICKS);
            if (holds_left == '0) begin
              ph = PH_HOLD_END;
            end else begin
              holds_left = holds_left - 1'b1;
            end
            done = 1'b1;
          end
        end
        PH_HOLD_END: begin
          ph = PH_BACK;
        end
        PH_BACK: begin
          back_goal = tgt;
          if (ramp < RAMP_W'(back_goal)) begin
            ph = PH_BACK_UP;
          end else if (ramp > RAMP_W'(back_goal)) begin
            ph = PH_BACK_DOWN;
          end else begin
            ph = PH_FINAL;
          end
        end
        PH_BACK_UP: begin
          if (ramp >= RAMP_W'(back_goal) || leave_b) begin
            ph = PH_FINAL;
          end else begin
            lvl_out   = level_on_wire(ramp);
            ramp      = ramp + RAMP_W'(regs.back_step);
            wait_left = regs.back_wait;
            wrote     = 1'b1;
            done      = 1'b1;
          end
        end
        PH_BACK_DOWN: begin
          if (ramp <= RAMP_W'(back_goal) || leave_b) begin
            ph = PH_FINAL;
          end else begin
            lvl_out   = level_on_wire(ramp);
            // A step past zero lands on zero.
            ramp      = (ramp >= RAMP_W'(regs.back_step)) ? ramp - RAMP_W'(regs.back_step)
                                                          : '0;
            wait_left = regs.back_wait;
            wrote     = 1'b1;
            done      = 1'b1;
          end
        end
        PH_FINAL: begin
          lvl_out    = tgt;
          finished_r = 1'b1;
          ph         = PH_IDLE;
          wait_left  = '0;
          wrote      = 1'b1;
          done       = 1'b1;
        end
        default: begin
          ph   = PH_IDLE;
          done = 1'b1;
        end
      endcase
    end
    return wrote;
  endfunction

  // Follow register writes and input words, and compare every result word taken.
  always @(posedge clk) begin : watch
    bl_word_t           want;
    bl_word_t           got;
    logic               wv;
    logic [LEVEL_W-1:0] wl;
    if (!rst_n) begin
      regs.start_level  = 12'd2;
      regs.end_level    = 12'd236;
      regs.up_step      = 8'd1;
      regs.back_step    = 8'd6;
      regs.fp_cap_level = 12'd255;
      regs.hold_steps   = 10'd600;
      regs.up_wait      = 8'd1;
      regs.back_wait    = 8'd6;
      mode_r     = MODE_OFF;
      running_r  = 1'b0;
      finished_r = 1'b1;
      retrig_r   = 1'b0;
      ph         = PH_IDLE;
      ramp       = '0;
      wait_left  = '0;
      holds_left = '0;
      back_goal  = '0;
      owed_q.delete();
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_START_LEVEL:  regs.start_level  = cfg_wdata[LEVEL_W-1:0];
          CFG_END_LEVEL:    regs.end_level    = cfg_wdata[LEVEL_W-1:0];
          CFG_UP_STEP:      regs.up_step      = cfg_wdata[STEP_W-1:0];
          CFG_BACK_STEP:    regs.back_step    = cfg_wdata[STEP_W-1:0];
          CFG_FP_CAP_LEVEL: regs.fp_cap_level = cfg_wdata[LEVEL_W-1:0];
          CFG_HOLD_STEPS:   regs.hold_steps   = cfg_wdata[HOLD_W-1:0];
          CFG_UP_WAIT:      regs.up_wait      = cfg_wdata[WAIT_W-1:0];
          CFG_BACK_WAIT:    regs.back_wait    = cfg_wdata[WAIT_W-1:0];
          default: ;
        endcase
      end

      // Predict the result of an accepted input word.
      if (in_ch.valid && in_ch.ready) begin
        wv = 1'b0;
        wl = '0;
        case (op_t'(in_ch.op))
          OP_TICK: begin
            if (ph == PH_IDLE) begin
              // A queued trigger is taken here, or dropped if the checks fail.
              if (retrig_r) begin
                retrig_r = 1'b0;
                if (in_ch.power_on && mode_r == MODE_TRIGGER && running_r) begin
                  ramp = RAMP_W'(regs.start_level);
                  ph   = PH_UP;
                  wv   = walk_phases(in_ch.target_level, in_ch.hbm_on, wl);
                end
              end
            end else begin
              if (wait_left != '0) wait_left = wait_left - 1'b1;
              if (wait_left == '0) wv = walk_phases(in_ch.target_level, in_ch.hbm_on, wl);
            end
          end
          OP_SET_MODE: begin
            if (in_ch.mode_value != MODE_BAD && in_ch.mode_value != mode_r) begin
              mode_r = in_ch.mode_value;
              if (mode_r == MODE_TRIGGER && running_r) begin
                finished_r = 1'b0;
                retrig_r   = 1'b1;
              end
            end
          end
          OP_START: begin
            running_r = 1'b1;
            if (mode_r == MODE_TRIGGER) begin
              finished_r = 1'b0;
              retrig_r   = 1'b1;
            end
          end
          default: begin
            // Stop cuts a running sequence short with its final write.
            finished_r = 1'b1;
            running_r  = 1'b0;
            retrig_r   = 1'b0;
            if (ph != PH_IDLE) begin
              ph = PH_FINAL;
              wv = walk_phases(in_ch.target_level, in_ch.hbm_on, wl);
            end
          end
        endcase
        want.write_valid = wv;
        want.write_level = wv ? wl : '0;
        want.finished    = finished_r;
        want.mode_now    = mode_r;
        want.seq_active  = (ph != PH_IDLE);
        owed_q.push_back(want);
      end

      // Compare a result word taken by the receiver with the oldest prediction.
      if (out_ch.valid && out_ch.ready) begin
        got.write_valid = out_ch.write_valid;
        got.write_level = out_ch.write_level;
        got.finished    = out_ch.finished;
        got.mode_now    = out_ch.mode_now;
        got.seq_active  = out_ch.seq_active;
        if (owed_q.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("%0t: result word with none expected: wv=%0b lvl=%0d fin=%0b mode=%0d act=%0b",
                     $realtime, got.write_valid, got.write_level, got.finished, got.mode_now,
                     got.seq_active);
          end
        end else begin
          want = owed_q.pop_front();
          if (got.write_valid !== want.write_valid || got.write_level !== want.write_level ||
              got.finished !== want.finished || got.mode_now !== want.mode_now ||
              got.seq_active !== want.seq_active) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: mismatch: expected wv=%0b lvl=%0d fin=%0b mode=%0d act=%0b",
                       $realtime, want.write_valid, want.write_level, want.finished,
                       want.mode_now, want.seq_active);
              $display("%0t:           got      wv=%0b lvl=%0d fin=%0b mode=%0d act=%0b",
                       $realtime, got.write_valid, got.write_level, got.finished,
                       got.mode_now, got.seq_active);
            end
          end
        end
      end
    end
    fail_count <= errs;
    words_owed <= owed_q.size();
  end

endmodule

### sim/backlight_flash_ramp_sequencer_tb.sv
`timescale 1ns / 1ps
// Top of the backlight ramp sequencer testbench: stimulus, receiver stalls and verdict.
module backlight_flash_ramp_sequencer_tb;
  import blfrs_pkg::*;

  localparam int WORDS_WANTED = 1800;
  localparam int NUM_SETS     = 12;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    words_owed;
  int                    words_sent;
  int                    burst_left;
  logic                  hold_req;
  int                    reg_plan [8];

  blfrs_in_if  in_ch ();
  blfrs_out_if out_ch ();

  backlight_flash_ramp_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  blfrs_ramp_checker ramp_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .words_owed (words_owed)
  );

  always #5 clk = ~clk;

  // Offer one input word and wait until it is taken; bursts are broken by random gaps.
  task automatic send_word(input op_t op, input logic [1:0] mv, input logic [LEVEL_W-1:0] tgt,
                           input logic hbm, input logic pwr);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.mode_value   <= mv;
    in_ch.target_level <= tgt;
    in_ch.hbm_on       <= hbm;
    in_ch.power_on     <= pwr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Wait until every predicted word has come back, with a short tail.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  // Write the whole register plan, one register per cycle.
  task automatic load_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(3'(i));
      cfg_wdata <= CFG_DATA_W'(reg_plan[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // A well-formed session: start and trigger, then mostly ticks with a few control words.
  task automatic run_session(input int len, input int tgt_hi);
    logic [LEVEL_W-1:0] goal;
    int                 r;
    goal = LEVEL_W'($urandom_range(0, tgt_hi));
    if ($urandom_range(0, 3) == 0) send_word(OP_SET_MODE, MODE_OFF, goal, 1'b0, 1'b1);
    if ($urandom_range(0, 1) == 1) begin
      send_word(OP_START, 2'($urandom), goal, 1'($urandom), 1'b1);
      send_word(OP_SET_MODE, MODE_TRIGGER, goal, 1'($urandom), 1'b1);
    end else begin
      send_word(OP_SET_MODE, MODE_TRIGGER, goal, 1'($urandom), 1'b1);
      send_word(OP_START, 2'($urandom), goal, 1'($urandom), 1'b1);
    end
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) goal = LEVEL_W'($urandom_range(0, tgt_hi));
      if (r < 88) begin
        send_word(OP_TICK, 2'($urandom), goal, 1'($urandom), $urandom_range(0, 11) != 0);
      end else if (r < 93) begin
        send_word(OP_SET_MODE, 2'($urandom), goal, 1'($urandom), 1'($urandom));
      end else if (r < 96) begin
        send_word(OP_START, 2'($urandom), goal, 1'($urandom), 1'($urandom));
      end else if (r < 98) begin
        send_word(OP_STOP, 2'($urandom), goal, 1'($urandom), 1'($urandom));
      end else begin
        send_word(op_t'(2'($urandom)), 2'($urandom), LEVEL_W'($urandom), 1'($urandom),
                  1'($urandom));
      end
    end
    if ($urandom_range(0, 1) == 1) send_word(OP_STOP, 2'($urandom), goal, 1'($urandom), 1'b1);
  endtask

  // Receiver: stall patterns of its own, and one long hold-off once asked for.
  initial begin : drain_side
    int kind;
    int span;
    bit held_off;
    held_off     = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      kind = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      if (hold_req && !held_off) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        held_off = 1'b1;
      end
      for (int c = 0; c < span; c++) begin
        case (kind)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom);
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= c[0];
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int tgt_hi;
    int phase_end;
    int sess_len;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_START_LEVEL;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_TICK;
    in_ch.mode_value   = MODE_OFF;
    in_ch.target_level = '0;
    in_ch.hbm_on       = 1'b0;
    in_ch.power_on     = 1'b0;
    hold_req           = 1'b0;
    burst_left         = 0;
    words_sent         = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a ramp that starts near the top so the return write saturates.
    reg_plan[CFG_START_LEVEL]  = 4000;
    reg_plan[CFG_END_LEVEL]    = 4095;
    reg_plan[CFG_UP_STEP]      = 200;
    reg_plan[CFG_BACK_STEP]    = 255;
    reg_plan[CFG_FP_CAP_LEVEL] = 4095;
    reg_plan[CFG_HOLD_STEPS]   = 0;
    reg_plan[CFG_UP_WAIT]      = 0;
    reg_plan[CFG_BACK_WAIT]    = 1;
    load_regs();
    // Unknown mode is ignored; an idle tick does nothing.
    send_word(OP_SET_MODE, MODE_BAD, '0, 1'b0, 1'b1);
    send_word(OP_TICK, MODE_OFF, 12'hFFF, 1'b1, 1'b0);
    // Trigger queued, queued again, then abandoned because the display is off.
    send_word(OP_START, MODE_OFF, '0, 1'b0, 1'b1);
    send_word(OP_SET_MODE, MODE_TRIGGER, '0, 1'b0, 1'b1);
    send_word(OP_START, MODE_TRIGGER, '0, 1'b0, 1'b1);
    send_word(OP_TICK, MODE_OFF, '0, 1'b0, 1'b0);
    // A full sequence: up ramp, one hold, saturated return write, final write.
    send_word(OP_START, MODE_EXIT, '0, 1'b0, 1'b1);
    repeat (11) send_word(OP_TICK, MODE_OFF, 12'hFFF, 1'b0, 1'b1);
    // Mode off mid-sequence leaves the return ramp running; stop then ends it.
    send_word(OP_SET_MODE, MODE_OFF, '0, 1'b0, 1'b1);
    send_word(OP_SET_MODE, MODE_TRIGGER, '0, 1'b0, 1'b1);
    send_word(OP_TICK, MODE_OFF, '0, 1'b1, 1'b1);
    send_word(OP_SET_MODE, MODE_OFF, '0, 1'b0, 1'b1);
    send_word(OP_TICK, MODE_OFF, '0, 1'b0, 1'b1);
    send_word(OP_STOP, MODE_OFF, '0, 1'b0, 1'b1);
    send_word(OP_SET_MODE, MODE_EXIT, 12'hFFF, 1'b1, 1'b1);
    settle();

    // Random part over several register settings, extremes first.
    for (int s = 0; s < NUM_SETS; s++) begin
      tgt_hi = 4095;
      case (s)
        0: begin
          // Everything at zero: zero steps and zero waits.
          reg_plan[CFG_START_LEVEL]  = 0;
          reg_plan[CFG_END_LEVEL]    = 0;
          reg_plan[CFG_UP_STEP]      = 0;
          reg_plan[CFG_BACK_STEP]    = 0;
          reg_plan[CFG_FP_CAP_LEVEL] = 0;
          reg_plan[CFG_HOLD_STEPS]   = 0;
          reg_plan[CFG_UP_WAIT]      = 0;
          reg_plan[CFG_BACK_WAIT]    = 0;
          tgt_hi = 20;
        end
        1: begin
          // Everything at its maximum.
          reg_plan[CFG_START_LEVEL]  = 4095;
          reg_plan[CFG_END_LEVEL]    = 4095;
          reg_plan[CFG_UP_STEP]      = 255;
          reg_plan[CFG_BACK_STEP]    = 255;
          reg_plan[CFG_FP_CAP_LEVEL] = 4095;
          reg_plan[CFG_HOLD_STEPS]   = 1023;
          reg_plan[CFG_UP_WAIT]      = 255;
          reg_plan[CFG_BACK_WAIT]    = 255;
        end
        2: begin
          // Ramps near the top of the range, so levels overshoot and saturate.
          reg_plan[CFG_START_LEVEL]  = $urandom_range(3800, 4095);
          reg_plan[CFG_END_LEVEL]    = 4095;
          reg_plan[CFG_UP_STEP]      = $urandom_range(100, 255);
          reg_plan[CFG_BACK_STEP]    = $urandom_range(1, 255);
          reg_plan[CFG_FP_CAP_LEVEL] = $urandom_range(0, 4095);
          reg_plan[CFG_HOLD_STEPS]   = $urandom_range(0, 2);
          reg_plan[CFG_UP_WAIT]      = $urandom_range(0, 2);
          reg_plan[CFG_BACK_WAIT]    = $urandom_range(0, 2);
        end
        default: begin
          // Short ramps and holds so that sequences finish inside a session.
          reg_plan[CFG_START_LEVEL]  = $urandom_range(0, 40);
          reg_plan[CFG_END_LEVEL]    = $urandom_range(0, 120);
          reg_plan[CFG_UP_STEP]      = $urandom_range(0, 10);
          reg_plan[CFG_BACK_STEP]    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                   : $urandom_range(1, 12);
          reg_plan[CFG_FP_CAP_LEVEL] = $urandom_range(0, 120);
          reg_plan[CFG_HOLD_STEPS]   = $urandom_range(0, 3);
          reg_plan[CFG_UP_WAIT]      = $urandom_range(0, 3);
          reg_plan[CFG_BACK_WAIT]    = $urandom_range(0, 3);
          tgt_hi = ($urandom_range(0, 3) == 0) ? 4095 : 150;
        end
      endcase
      load_regs();
      if (s == 3) hold_req <= 1'b1;
      phase_end = words_sent + WORDS_WANTED / NUM_SETS;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 5) != 0) begin
          // Keep the session inside what is left of this setting's share of words.
          sess_len = $urandom_range(10, 80);
          if (sess_len > phase_end - words_sent) sess_len = phase_end - words_sent;
          run_session(sess_len, tgt_hi);
        end else begin
          // Noise: words with every field random.
          repeat ($urandom_range(1, 10)) begin
            send_word(op_t'(2'($urandom)), 2'($urandom), LEVEL_W'($urandom), 1'($urandom),
                      1'($urandom));
          end
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
hdl/blfrs_pkg.sv
hdl/blfrs_ifs.sv
hdl/blfrs_seq.sv
hdl/backlight_flash_ramp_sequencer.sv
sim/blfrs_ramp_checker.sv
sim/backlight_flash_ramp_sequencer_tb.sv
